>>> hw/rtl/lfsc_pkg.sv
package lfsc_pkg;

    // Sequencer states of the steering controller.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_MUL_P,
        S_MUL_D,
        S_FIN
    } state_t;

    // Drive mode codes on the result channel.
    localparam logic [2:0] MODE_STOP    = 3'd0;
    localparam logic [2:0] MODE_DARK    = 3'd1;
    localparam logic [2:0] MODE_CROSS   = 3'd2;
    localparam logic [2:0] MODE_CORNER  = 3'd3;
    localparam logic [2:0] MODE_COAST   = 3'd4;
    localparam logic [2:0] MODE_SEARCH  = 3'd5;
    localparam logic [2:0] MODE_PD      = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_BASE     = 3'd0;
    localparam logic [2:0] REG_PROP     = 3'd1;
    localparam logic [2:0] REG_DERIV    = 3'd2;
    localparam logic [2:0] REG_POUTER   = 3'd3;
    localparam logic [2:0] REG_PINNER   = 3'd4;
    localparam logic [2:0] REG_CLIMIT   = 3'd5;
    localparam logic [2:0] REG_BWINDOW  = 3'd6;
    localparam logic [2:0] REG_FINISH   = 3'd7;

    // Speed limits and fixed behavior constants, Q4 px/s where speeds.
    localparam int SPD_W = 20;
    localparam logic signed [SPD_W-1:0] SPD_MAX  = 20'sd2240;
    localparam logic signed [SPD_W-1:0] SPD_MIN  = -20'sd960;
    localparam logic signed [SPD_W-1:0] ARC_BASE = 20'sd480;
    localparam logic signed [SPD_W-1:0] ARC_TURN = 20'sd192;
    localparam logic [7:0] COAST_FRAMES = 8'd35;
    localparam logic [7:0] LOST_MIN     = 8'd3;

    // Saturating frame counter increment.
    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        logic [7:0] r;
        r = (c == 8'hFF) ? 8'hFF : c + 8'd1;
        return r;
    endfunction

    // Clamp a wide speed into the commanded range.
    function automatic logic signed [12:0] clamp_spd(input logic signed [SPD_W-1:0] v);
        logic signed [SPD_W-1:0] r;
        r = v;
        if (r > SPD_MAX) r = SPD_MAX;
        if (r < SPD_MIN) r = SPD_MIN;
        return r[12:0];
    endfunction

endpackage

>>> hw/rtl/lfsc_sensor_if.sv
interface lfsc_sensor_if #(parameter int NUM_SENSORS = 5);
    logic                   valid;
    logic                   ready;
    logic [NUM_SENSORS-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink (input valid, input sensor_bits, output ready);
endinterface

>>> hw/rtl/lfsc_steer_if.sv
interface lfsc_steer_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] left_speed;
    logic signed [12:0] right_speed;
    logic [2:0]         drive_mode;

    modport source (output valid, output left_speed, output right_speed,
                    output drive_mode, input ready);
    modport sink (input valid, input left_speed, input right_speed,
                  input drive_mode, output ready);
endinterface

>>> hw/rtl/line_follower_steering_controller.sv
// Each frame goes through a scan, a prep step, a divide, a multiply step per gain and a decision;
// one adder scans a sensor per cycle, a restoring divider retires one quotient bit per
// cycle, and one multiplier is used twice.
// The next frame is taken once the result is in the output register.
// Reset (rst_n, asynchronous, active low) loads register defaults and resets all
// tracking state; the block is ready as soon as reset is released.
module line_follower_steering_controller #(
    parameter int NUM_SENSORS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    lfsc_sensor_if.sink        sensor_in,
    lfsc_steer_if.source       steer_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W  = (NUM_SENSORS > 2) ? $clog2(NUM_SENSORS) : 1;
    localparam int CW     = $clog2(NUM_SENSORS + 1);
    localparam int SH_W   = $clog2(NUM_SENSORS * NUM_SENSORS) + 3;
    localparam int DIV_W  = SH_W + 7;
    localparam int DC_W   = $clog2(DIV_W + 1);
    localparam int HALF   = NUM_SENSORS / 2;

    // Configuration registers.
    logic [11:0]        base_speed_reg;
    logic [10:0]        prop_gain_reg;
    logic [10:0]        deriv_gain_reg;
    logic signed [12:0] pivot_outer_reg;
    logic signed [12:0] pivot_inner_reg;
    logic [7:0]         corner_limit_reg;
    logic [7:0]         bar_span_reg;
    logic [7:0]         finish_frames_reg;

    logic       cfg_write;
    logic [2:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];

    // Register writes on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg    <= 12'd576;
            prop_gain_reg     <= 11'd416;
            deriv_gain_reg    <= 11'd144;
            pivot_outer_reg   <= 13'sd1120;
            pivot_inner_reg   <= -13'sd320;
            corner_limit_reg  <= 8'd60;
            bar_span_reg      <= 8'd25;
            finish_frames_reg <= 8'd25;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                lfsc_pkg::REG_BASE:    base_speed_reg    <= pwdata[11:0];
                lfsc_pkg::REG_PROP:    prop_gain_reg     <= pwdata[10:0];
                lfsc_pkg::REG_DERIV:   deriv_gain_reg    <= pwdata[10:0];
                lfsc_pkg::REG_POUTER:  pivot_outer_reg   <= pwdata[12:0];
                lfsc_pkg::REG_PINNER:  pivot_inner_reg   <= pwdata[12:0];
                lfsc_pkg::REG_CLIMIT:  corner_limit_reg  <= pwdata[7:0];
                lfsc_pkg::REG_BWINDOW: bar_span_reg      <= pwdata[7:0];
                lfsc_pkg::REG_FINISH:  finish_frames_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (cfg_idx)
            lfsc_pkg::REG_BASE:    prdata = {20'd0, base_speed_reg};
            lfsc_pkg::REG_PROP:    prdata = {21'd0, prop_gain_reg};
            lfsc_pkg::REG_DERIV:   prdata = {21'd0, deriv_gain_reg};
            lfsc_pkg::REG_POUTER:  prdata = {19'd0, pivot_outer_reg};
            lfsc_pkg::REG_PINNER:  prdata = {19'd0, pivot_inner_reg};
            lfsc_pkg::REG_CLIMIT:  prdata = {24'd0, corner_limit_reg};
            lfsc_pkg::REG_BWINDOW: prdata = {24'd0, bar_span_reg};
            lfsc_pkg::REG_FINISH:  prdata = {24'd0, finish_frames_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath registers.
    lfsc_pkg::state_t state_reg, state_next;

    logic [NUM_SENSORS-1:0]  bits_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CW-1:0]           dark_reg;
    logic signed [SH_W-1:0]  sh_reg;
    logic signed [SH_W-1:0]  line_sum_reg;
    logic [CW-1:0]           line_cnt_reg;
    logic [DIV_W-1:0]        dq_reg;
    logic [CW:0]             rem_reg;
    logic [DC_W-1:0]         div_cnt_reg;
    logic signed [11:0]      err_w;
    logic signed [27:0]      acc_reg;

    // Tracking state.
    logic signed [11:0] last_error_reg, last_error_next;
    logic               side_right_reg, side_right_next;
    logic [7:0]         lost_count_reg, lost_count_next;
    logic [7:0]         all_dark_reg, all_dark_next;
    logic [7:0]         bar_age_reg, bar_age_next;
    logic [7:0]         corner_count_reg, corner_count_next;
    logic               corner_right_reg, corner_right_next;
    logic               started_reg, started_next;
    logic               done_reg, done_next;

    // Result register.
    logic               out_valid_reg;
    logic signed [12:0] left_reg, right_reg;
    logic [2:0]         mode_reg;
    logic signed [12:0] left_next, right_next;
    logic [2:0]         mode_next;

    logic in_fire;
    logic fin_go;
    logic scan_last;
    logic div_last;

    assign in_fire   = sensor_in.valid && sensor_in.ready;
    assign fin_go    = (state_reg == lfsc_pkg::S_FIN) && (!out_valid_reg || steer_out.ready);
    assign scan_last = (idx_reg == IDX_W'(NUM_SENSORS - 1));
    assign div_last  = (div_cnt_reg == DC_W'(DIV_W - 1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfsc_pkg::S_IDLE:  if (in_fire) state_next = lfsc_pkg::S_SCAN;
            lfsc_pkg::S_SCAN:  if (scan_last) state_next = lfsc_pkg::S_PREP;
            lfsc_pkg::S_PREP:  state_next = lfsc_pkg::S_DIV;
            lfsc_pkg::S_DIV:   if (div_last) state_next = lfsc_pkg::S_MUL_P;
            lfsc_pkg::S_MUL_P: state_next = lfsc_pkg::S_MUL_D;
            lfsc_pkg::S_MUL_D: state_next = lfsc_pkg::S_FIN;
            lfsc_pkg::S_FIN:   if (fin_go) state_next = lfsc_pkg::S_IDLE;
            default:           state_next = lfsc_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        sensor_in.ready       = (state_reg == lfsc_pkg::S_IDLE);
        steer_out.valid       = out_valid_reg;
        steer_out.left_speed  = left_reg;
        steer_out.right_speed = right_reg;
        steer_out.drive_mode  = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lfsc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Sensor scan: one sensor per cycle through one adder.
    logic signed [SH_W-1:0] pos;
    assign pos = SH_W'(2 * idx_reg) - SH_W'(NUM_SENSORS - 1);

    // Line polarity, taken from the scan totals.
    logic                   majority;
    logic                   inverted;
    assign majority = dark_reg > CW'(HALF);
    assign inverted = majority && bits_reg[0] && bits_reg[NUM_SENSORS-1];

    // Restoring divider step.
    logic [CW:0] rem_shift;
    logic        rem_ge;
    assign rem_shift = {rem_reg[CW-1:0], dq_reg[DIV_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, line_cnt_reg};

    logic [SH_W-1:0] line_abs;
    assign line_abs = line_sum_reg[SH_W-1] ? SH_W'(-line_sum_reg) : line_sum_reg;

    // Shared multiplier: gain times error term.
    logic [10:0]        mul_a;
    logic signed [12:0] mul_b;
    logic signed [24:0] mul_p;
    logic signed [12:0] derr;
    assign derr  = 13'(err_w) - 13'(last_error_reg);
    assign mul_a = (state_reg == lfsc_pkg::S_MUL_P) ? prop_gain_reg : deriv_gain_reg;
    assign mul_b = (state_reg == lfsc_pkg::S_MUL_P) ? 13'(err_w) : derr;
    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lfsc_pkg::S_IDLE:
            begin
                bits_reg <= sensor_in.sensor_bits;
                idx_reg  <= '0;
                dark_reg <= '0;
                sh_reg   <= '0;
            end
            lfsc_pkg::S_SCAN:
            begin
                if (bits_reg[idx_reg])
                begin
                    dark_reg <= dark_reg + CW'(1);
                    sh_reg   <= sh_reg + pos;
                end
                idx_reg <= idx_reg + IDX_W'(1);
            end
            lfsc_pkg::S_PREP:
            begin
                // Light positions sum to the negative of the dark ones, so the
                // magnitude is the same either way.
                line_sum_reg <= inverted ? -sh_reg : sh_reg;
                line_cnt_reg <= inverted ? CW'(NUM_SENSORS) - dark_reg : dark_reg;
                dq_reg       <= {sh_reg[SH_W-1] ? SH_W'(-sh_reg) : sh_reg, 7'd0};
                rem_reg      <= '0;
                div_cnt_reg  <= '0;
            end
            lfsc_pkg::S_DIV:
            begin
                rem_reg     <= rem_ge ? rem_shift - {1'b0, line_cnt_reg} : rem_shift;
                dq_reg      <= {dq_reg[DIV_W-2:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + DC_W'(1);
            end
            lfsc_pkg::S_MUL_P:
            begin
                acc_reg <= 28'(mul_p) + 28'sd128;
            end
            lfsc_pkg::S_MUL_D:
            begin
                acc_reg <= acc_reg + 28'(mul_p);
            end
            default: ;
        endcase
    end

    // Signed error from the quotient magnitude.
    always_comb
    begin
        if (line_cnt_reg == '0)
            err_w = '0;
        else if (line_sum_reg[SH_W-1])
            err_w = -$signed(dq_reg[11:0]);
        else
            err_w = $signed(dq_reg[11:0]);
    end

    // Frame decision: mode, speeds and tracking updates.
    logic signed [lfsc_pkg::SPD_W-1:0] base_w, corr_w, po_w, pi_w;
    logic [15:0] sh_abs5, dark2, asum5, cnt2, asum1;
    logic [SH_W-1:0] sh_abs;
    logic            handled;

    always_comb
    begin
        base_w  = lfsc_pkg::SPD_W'(base_speed_reg);
        corr_w  = lfsc_pkg::SPD_W'(acc_reg >>> 8);
        po_w    = lfsc_pkg::SPD_W'(pivot_outer_reg);
        pi_w    = lfsc_pkg::SPD_W'(pivot_inner_reg);
        sh_abs  = sh_reg[SH_W-1] ? SH_W'(-sh_reg) : sh_reg;
        sh_abs5 = 16'(sh_abs) * 16'd5;
        dark2   = 16'(dark_reg) * 16'd2;
        asum5   = 16'(line_abs) * 16'd5;
        asum1   = 16'(line_abs);
        cnt2    = 16'(line_cnt_reg) * 16'd2;
        handled = 1'b0;

        last_error_next   = last_error_reg;
        side_right_next   = side_right_reg;
        lost_count_next   = lost_count_reg;
        all_dark_next     = all_dark_reg;
        bar_age_next      = bar_age_reg;
        corner_count_next = corner_count_reg;
        corner_right_next = corner_right_reg;
        started_next      = started_reg;
        done_next         = done_reg;
        left_next         = '0;
        right_next        = '0;
        mode_next         = lfsc_pkg::MODE_STOP;

        if (done_reg)
        begin
            handled = 1'b1;
        end
        else if (dark_reg == CW'(NUM_SENSORS))
        begin
            handled           = 1'b1;
            all_dark_next     = lfsc_pkg::sat_inc(all_dark_reg);
            corner_count_next = '0;
            if (started_reg && all_dark_next > finish_frames_reg)
                done_next = 1'b1;
            else
            begin
                left_next  = lfsc_pkg::clamp_spd(base_w);
                right_next = lfsc_pkg::clamp_spd(base_w);
                mode_next  = lfsc_pkg::MODE_DARK;
            end
        end
        else
        begin
            all_dark_next = '0;
            started_next  = 1'b1;
            // Wide bar: remember which side it leans to.
            if (!inverted && dark_reg >= CW'(3))
            begin
                bar_age_next = '0;
                if (sh_abs5 > dark2)
                    side_right_next = !sh_reg[SH_W-1] && (sh_reg != '0);
            end
            else
                bar_age_next = lfsc_pkg::sat_inc(bar_age_reg);

            if (majority && !inverted)
            begin
                handled         = 1'b1;
                lost_count_next = '0;
                left_next       = lfsc_pkg::clamp_spd(base_w);
                right_next      = lfsc_pkg::clamp_spd(base_w);
                mode_next       = lfsc_pkg::MODE_CROSS;
            end
            else if (corner_count_reg != '0)
            begin
                // Latched corner continues unless the line is back near center or the corner limit is passed.
                corner_count_next = lfsc_pkg::sat_inc(corner_count_reg);
                if ((line_cnt_reg != '0 && asum1 <= cnt2)
                    || corner_count_next > corner_limit_reg)
                    corner_count_next = '0;
                else
                begin
                    handled    = 1'b1;
                    left_next  = lfsc_pkg::clamp_spd(corner_right_reg ? po_w : pi_w);
                    right_next = lfsc_pkg::clamp_spd(corner_right_reg ? pi_w : po_w);
                    mode_next  = lfsc_pkg::MODE_CORNER;
                end
            end

            if (!handled && line_cnt_reg == '0)
            begin
                lost_count_next = lfsc_pkg::sat_inc(lost_count_reg);
                if (lost_count_next >= lfsc_pkg::LOST_MIN && bar_age_next < bar_span_reg)
                begin
                    corner_count_next = 8'd1;
                    corner_right_next = side_right_next;
                    left_next  = lfsc_pkg::clamp_spd(side_right_next ? po_w : pi_w);
                    right_next = lfsc_pkg::clamp_spd(side_right_next ? pi_w : po_w);
                    mode_next  = lfsc_pkg::MODE_CORNER;
                end
                else if (lost_count_next <= lfsc_pkg::COAST_FRAMES)
                begin
                    left_next  = lfsc_pkg::clamp_spd(base_w);
                    right_next = lfsc_pkg::clamp_spd(base_w);
                    mode_next  = lfsc_pkg::MODE_COAST;
                end
                else
                begin
                    left_next  = side_right_next ? lfsc_pkg::clamp_spd(lfsc_pkg::ARC_BASE
                                     + lfsc_pkg::ARC_TURN)
                                 : lfsc_pkg::clamp_spd(lfsc_pkg::ARC_BASE - lfsc_pkg::ARC_TURN);
                    right_next = side_right_next ? lfsc_pkg::clamp_spd(lfsc_pkg::ARC_BASE
                                     - lfsc_pkg::ARC_TURN)
                                 : lfsc_pkg::clamp_spd(lfsc_pkg::ARC_BASE + lfsc_pkg::ARC_TURN);
                    mode_next  = lfsc_pkg::MODE_SEARCH;
                end
            end
            else if (!handled)
            begin
                // Clamped PD steering.
                lost_count_next = '0;
                if (asum5 > cnt2)
                    side_right_next = !line_sum_reg[SH_W-1] && (line_sum_reg != '0);
                last_error_next = err_w;
                left_next       = lfsc_pkg::clamp_spd(base_w + corr_w);
                right_next      = lfsc_pkg::clamp_spd(base_w - corr_w);
                mode_next       = lfsc_pkg::MODE_PD;
            end
        end
    end

    // Tracking state commits when the result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg   <= '0;
            side_right_reg   <= 1'b1;
            lost_count_reg   <= '0;
            all_dark_reg     <= '0;
            bar_age_reg      <= 8'hFF;
            corner_count_reg <= '0;
            corner_right_reg <= 1'b0;
            started_reg      <= 1'b0;
            done_reg         <= 1'b0;
        end
        else if (fin_go)
        begin
            last_error_reg   <= last_error_next;
            side_right_reg   <= side_right_next;
            lost_count_reg   <= lost_count_next;
            all_dark_reg     <= all_dark_next;
            bar_age_reg      <= bar_age_next;
            corner_count_reg <= corner_count_next;
            corner_right_reg <= corner_right_next;
            started_reg      <= started_next;
            done_reg         <= done_next;
        end
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_go)
            out_valid_reg <= 1'b1;
        else if (steer_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            mode_reg  <= mode_next;
        end
    end

    // A new result appears only out of the decision step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lfsc_pkg::S_FIN))
        else $error("result valid without a decision step");

    // Once finished, the controller stays finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("finished flag cleared");

    // A corner result always leaves a latched turn behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && mode_next == lfsc_pkg::MODE_CORNER) |=> corner_count_reg != 8'd0)
        else $error("corner result without latched turn");

    // Finished frames report stop with zero speeds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && done_reg) |=> (mode_reg == lfsc_pkg::MODE_STOP && left_reg == 13'sd0))
        else $error("finished controller not stopped");

endmodule
